>>> src/pbd_pkg.sv
// ---------------------------------------------------------------------------
// pbd_pkg: shared types and constants for the pulse beat detector
// Field widths, function and register codes, reset values and the queue
// item that travels from the front end to the back end.
// ---------------------------------------------------------------------------
package pbd_pkg;

  // Rate history depth (1..16)
  localparam int RING_DEPTH = 4;
  localparam int RING_IDX_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

  // Field widths
  localparam int FUNC_W     = 2;
  localparam int SAMPLE_W   = 10;
  localparam int TIME_W     = 32;
  localparam int RATE_W     = 8;
  localparam int COUNT_W    = 5;
  localparam int TOTAL_W    = RATE_W + COUNT_W - 1;
  localparam int DIV_W      = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Function codes on the input channel
  localparam logic [FUNC_W-1:0] FUNC_SAMPLE = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_LOAD   = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_REFRACTORY = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_INT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_INT    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HYST       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_THR   = 3'd4;

  // Reset values and arithmetic constants
  localparam logic [15:0]         REFRACTORY_RST = 16'd300;
  localparam logic [15:0]         MIN_INT_RST    = 16'd300;
  localparam logic [15:0]         MAX_INT_RST    = 16'd3000;
  localparam logic [SAMPLE_W-1:0] HYST_RST       = 10'd100;
  localparam logic [SAMPLE_W-1:0] INIT_THR_RST   = 10'd512;
  localparam logic [DIV_W-1:0]    RATE_NUM       = 16'd60000;
  localparam logic [RATE_W-1:0]   RATE_MAX       = 8'd255;

  // Decoded operation
  typedef enum logic [1:0] {
    OP_SAMPLE,
    OP_CLEAR,
    OP_LOAD,
    OP_NOP
  } op_t;

  // Queue entry between front and back end
  typedef struct packed {
    op_t                 op;
    logic [SAMPLE_W-1:0] sample;
    logic [TIME_W-1:0]   time_ms;
  } item_t;

endpackage

>>> src/pbd_front.sv
// ---------------------------------------------------------------------------
// pbd_front: input front end
// Accepts input transfers, decodes the function code and holds the items
// in a two-entry queue that the back end drains at its own pace.
// ---------------------------------------------------------------------------
module pbd_front import pbd_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [FUNC_W-1:0]   in_func,
  input  logic [SAMPLE_W-1:0] in_sample,
  input  logic [TIME_W-1:0]   in_time_ms,
  output logic                q_valid,
  output item_t               q_item,
  input  logic                q_pop
);

  item_t      q_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;
  item_t      item_in;
  logic       push;
  logic       pop;

  // Decode function code
  always_comb begin
    item_in.sample  = in_sample;
    item_in.time_ms = in_time_ms;
    case (in_func)
      FUNC_SAMPLE: item_in.op = OP_SAMPLE;
      FUNC_CLEAR:  item_in.op = OP_CLEAR;
      FUNC_LOAD:   item_in.op = OP_LOAD;
      default:     item_in.op = OP_NOP;
    endcase
  end

  assign in_ready = (cnt_r != 2'd2);
  assign q_valid  = (cnt_r != 2'd0);
  assign q_item   = q_r[rd_ptr_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_pop && q_valid;

  // Queue pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) q_r[wr_ptr_r] <= item_in;
  end

endmodule

>>> src/pbd_div.sv
// ---------------------------------------------------------------------------
// pbd_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle. done pulses for one
// cycle once the last step is taken, with the quotient on its output.
// ---------------------------------------------------------------------------
module pbd_div import pbd_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [DIV_W-1:0] divisor,
  output logic             done,
  output logic [DIV_W-1:0] quotient
);

  localparam int STEP_W = $clog2(DIV_W);

  logic [DIV_W-1:0]  quo_r;
  logic [DIV_W-1:0]  rem_r;
  logic [DIV_W-1:0]  dvs_r;
  logic [STEP_W-1:0] step_r;
  logic              busy_r;
  logic              done_r;
  logic [DIV_W:0]    rem_sh;
  logic [DIV_W:0]    trial;
  logic              fits;

  // One restoring step
  assign rem_sh   = {rem_r, quo_r[DIV_W-1]};
  assign trial    = rem_sh - {1'b0, dvs_r};
  assign fits     = !trial[DIV_W];
  assign done     = done_r;
  assign quotient = quo_r;

  // Step control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      // pulse once the last step is taken
      done_r <= busy_r && !start && (step_r == STEP_W'(DIV_W - 1));
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == STEP_W'(DIV_W - 1)) busy_r <= 1'b0;
      end
    end
  end

  // Remainder and quotient shift
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= fits ? trial[DIV_W-1:0] : rem_sh[DIV_W-1:0];
      quo_r <= {quo_r[DIV_W-2:0], fits};
    end
  end

endmodule

>>> src/pbd_back.sv
// ---------------------------------------------------------------------------
// pbd_back: detector back end
// Holds the configuration and detector state, runs one queued item at a
// time through a sequencer (update, rate division, ring sum, mean
// division) and presents the result in an output register.
// ---------------------------------------------------------------------------
module pbd_back import pbd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_valid,
  input  item_t                 q_item,
  output logic                  q_pop,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_beat,
  output logic [RATE_W-1:0]     out_bpm,
  output logic [COUNT_W-1:0]    out_reading_count
);

  // Sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_RATE  = 3'd2;
  localparam logic [2:0] S_SUM   = 3'd3;
  localparam logic [2:0] S_MEAN  = 3'd4;
  localparam logic [2:0] S_MWAIT = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  logic [2:0]            state_r;
  item_t                 cur_r;

  // Configuration
  logic [15:0]           refr_r;
  logic [15:0]           min_int_r;
  logic [15:0]           max_int_r;
  logic [SAMPLE_W-1:0]   hyst_r;

  // Detector state
  logic [RATE_W-1:0]     ring_r [RING_DEPTH];
  logic [RING_IDX_W-1:0] ptr_r;
  logic [RING_IDX_W-1:0] ptr_nxt;
  logic [TIME_W-1:0]     int_start_r;
  logic [TIME_W-1:0]     last_det_r;
  logic                  flag_r;
  logic [SAMPLE_W-1:0]   thr_r;
  logic [SAMPLE_W-1:0]   thr_nxt;

  // Per-item working registers
  logic                  beat_r;
  logic [RING_IDX_W-1:0] idx_r;
  logic [TOTAL_W-1:0]    total_r;
  logic [COUNT_W-1:0]    count_r;
  logic [RATE_W-1:0]     bpm_r;

  // Output register
  logic                  out_valid_r;
  logic                  out_beat_r;
  logic [RATE_W-1:0]     out_bpm_r;
  logic [COUNT_W-1:0]    out_count_r;

  // Update logic
  logic [TIME_W-1:0]     since_det;
  logic [TIME_W-1:0]     interval;
  logic                  is_beat;
  logic                  in_range;
  logic [SAMPLE_W:0]     rearm_lvl;
  logic                  rearm;
  logic [14:0]           thr_iir;
  logic [RATE_W-1:0]     ring_entry;
  logic [RATE_W-1:0]     rate_sat;

  // Divider hookup
  logic                  div_start;
  logic [DIV_W-1:0]      div_dividend;
  logic [DIV_W-1:0]      div_divisor;
  logic                  div_done;
  logic [DIV_W-1:0]      div_quo;

  // Beat decision and interval check
  assign since_det = cur_r.time_ms - last_det_r;
  assign interval  = cur_r.time_ms - int_start_r;
  assign is_beat   = (cur_r.op == OP_SAMPLE) && (cur_r.sample > thr_r) && !flag_r &&
                     (since_det > {16'd0, refr_r});
  assign in_range  = (interval > {16'd0, min_int_r}) && (interval < {16'd0, max_int_r});

  // Re-arm level; a negative level never re-arms
  assign rearm_lvl = {1'b0, thr_r} - {1'b0, hyst_r};
  assign rearm     = !rearm_lvl[SAMPLE_W] && (cur_r.sample < rearm_lvl[SAMPLE_W-1:0]);

  // Threshold smoothing: (31*thr + sample) / 32
  assign thr_iir = {thr_r, 5'd0} - {5'd0, thr_r} + {5'd0, cur_r.sample};
  assign thr_nxt = thr_iir[14:5];

  assign ptr_nxt    = (ptr_r == RING_IDX_W'(RING_DEPTH - 1)) ? '0 : ptr_r + 1'b1;
  assign ring_entry = ring_r[idx_r];
  assign rate_sat   = (div_quo > {8'd0, RATE_MAX}) ? RATE_MAX : div_quo[RATE_W-1:0];

  // Divider operand select: rate in update step, mean afterwards
  always_comb begin
    div_start    = 1'b0;
    div_dividend = DIV_W'(total_r);
    div_divisor  = DIV_W'(count_r);
    if (state_r == S_EXEC) begin
      div_start    = is_beat && in_range;
      div_dividend = RATE_NUM;
      div_divisor  = interval[DIV_W-1:0];
    end else if (state_r == S_MEAN) begin
      div_start    = (count_r != '0);
    end
  end

  assign q_pop             = (state_r == S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_beat          = out_beat_r;
  assign out_bpm           = out_bpm_r;
  assign out_reading_count = out_count_r;

  pbd_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Current item capture
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && q_valid) cur_r <= q_item;
  end

  // Sequencer, detector state, configuration and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      refr_r      <= REFRACTORY_RST;
      min_int_r   <= MIN_INT_RST;
      max_int_r   <= MAX_INT_RST;
      hyst_r      <= HYST_RST;
      for (int i = 0; i < RING_DEPTH; i++) ring_r[i] <= '0;
      ptr_r       <= '0;
      int_start_r <= '0;
      last_det_r  <= '0;
      flag_r      <= 1'b0;
      // threshold returns to the INIT_THR_RST default here as well
      thr_r       <= INIT_THR_RST;
      beat_r      <= 1'b0;
      idx_r       <= '0;
      total_r     <= '0;
      count_r     <= '0;
      bpm_r       <= '0;
      out_valid_r <= 1'b0;
      out_beat_r  <= 1'b0;
      out_bpm_r   <= '0;
      out_count_r <= '0;
    end else begin
      // Configuration writes; writes to the initial threshold index are ignored
      if (cfg_we) begin
        case (cfg_index)
          CFG_REFRACTORY: refr_r    <= cfg_data;
          CFG_MIN_INT:    min_int_r <= cfg_data;
          CFG_MAX_INT:    max_int_r <= cfg_data;
          CFG_HYST:       hyst_r    <= cfg_data[SAMPLE_W-1:0];
          CFG_INIT_THR:   ;
          default:        ;
        endcase
      end

      // S_OUT reloads the output register itself
      if (out_valid_r && out_ready && (state_r != S_OUT)) out_valid_r <= 1'b0;

      case (state_r)
        S_IDLE: begin
          if (q_valid) state_r <= S_EXEC;
        end

        S_EXEC: begin
          beat_r  <= is_beat;
          idx_r   <= '0;
          total_r <= '0;
          count_r <= '0;
          state_r <= (is_beat && in_range) ? S_RATE : S_SUM;
          case (cur_r.op)
            OP_SAMPLE: begin
              if (is_beat) begin
                flag_r      <= 1'b1;
                last_det_r  <= cur_r.time_ms;
                int_start_r <= cur_r.time_ms;
              end else begin
                if (rearm) flag_r <= 1'b0;
                thr_r <= thr_nxt;
              end
            end
            OP_CLEAR: begin
              for (int i = 0; i < RING_DEPTH; i++) ring_r[i] <= '0;
              ptr_r       <= '0;
              int_start_r <= '0;
              flag_r      <= 1'b0;
            end
            OP_LOAD: thr_r <= cur_r.sample;
            default: ;
          endcase
        end

        // Wait for 60000 / interval, store saturated rate
        S_RATE: begin
          if (div_done) begin
            ring_r[ptr_r] <= rate_sat;
            ptr_r         <= ptr_nxt;
            state_r       <= S_SUM;
          end
        end

        // Sum nonzero ring entries, one per cycle
        S_SUM: begin
          if (ring_entry != '0) begin
            total_r <= total_r + TOTAL_W'(ring_entry);
            count_r <= count_r + 1'b1;
          end
          idx_r <= idx_r + 1'b1;
          if (idx_r == RING_IDX_W'(RING_DEPTH - 1)) state_r <= S_MEAN;
        end

        S_MEAN: begin
          if (count_r == '0) begin
            bpm_r   <= '0;
            state_r <= S_OUT;
          end else begin
            state_r <= S_MWAIT;
          end
        end

        S_MWAIT: begin
          if (div_done) begin
            bpm_r   <= div_quo[RATE_W-1:0];
            state_r <= S_OUT;
          end
        end

        // Load the output register once it is free
        S_OUT: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_beat_r  <= beat_r;
            out_bpm_r   <= bpm_r;
            out_count_r <= count_r;
            state_r     <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

>>> src/pulse_beat_detect_bpm.sv
// ---------------------------------------------------------------------------
// pulse_beat_detect_bpm: pulse beat detector with rate averaging
// Detects beats against an adaptive threshold, keeps a ring of recent
// rates (60000 / interval) and reports their mean with every result.
//
//   channel  signals                                    transfer when
//   -------  -----------------------------------------  -----------------
//   in       in_func, in_sample, in_time_ms             in_valid&in_ready
//   out      out_beat, out_bpm, out_reading_count       out_valid&out_ready
//   cfg      cfg_index, cfg_data                        cfg_we
//
// In the back end the restoring divider runs once for a stored rate and
// once for the mean, and the ring sum steps through its entries in turn.
// Front and back are parted by a two-entry queue, so input transfers go on
// until it fills while the back end works or the output register waits.
// rst_n is synchronous; no clearing pass is needed.
// ---------------------------------------------------------------------------
module pulse_beat_detect_bpm import pbd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [FUNC_W-1:0]     in_func,
  input  logic [SAMPLE_W-1:0]   in_sample,
  input  logic [TIME_W-1:0]     in_time_ms,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_beat,
  output logic [RATE_W-1:0]     out_bpm,
  output logic [COUNT_W-1:0]    out_reading_count,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic  q_valid;
  item_t q_item;
  logic  q_pop;

  // Accept and decode
  pbd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_func    (in_func),
    .in_sample  (in_sample),
    .in_time_ms (in_time_ms),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop)
  );

  // Execute and report
  pbd_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (q_valid),
    .q_item            (q_item),
    .q_pop             (q_pop),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_beat          (out_beat),
    .out_bpm           (out_bpm),
    .out_reading_count (out_reading_count)
  );

endmodule

>>> dv/pulse_beat_detect_bpm_test.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// pulse_beat_detect_bpm_test: self-checking bench for the beat detector
// Drives sample, clear and threshold-load items through the input channel
// with random gaps and result-side stalls. A scoreboard class tracks the
// detector state (threshold, arming, ring of rates) and checks every
// result transfer in order. Runs a directed sequence at reset settings,
// then random pulse trains and noise under several register settings.
// ---------------------------------------------------------------------------
module pulse_beat_detect_bpm_test;
  import pbd_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int TAIL_CYCLES  = 64;
  localparam int HOLD_CYCLES  = 300;
  localparam int PHASE_COUNT  = 6;
  localparam int PHASE_ITEMS  = 100;
  localparam int CFG_SLOTS    = 2 ** CFG_IDX_W;
  localparam int IIR_KEEP     = 31;
  localparam int IIR_DIV      = 32;
  localparam logic [FUNC_W-1:0]     FUNC_UNUSED = 2'd3;
  localparam logic [SAMPLE_W-1:0]   LEVEL_TOP   = '1;
  localparam logic [CFG_DATA_W-1:0] CFG_TOP     = '1;

  typedef struct packed {
    logic               beat;
    logic [RATE_W-1:0]  bpm;
    logic [COUNT_W-1:0] readings;
  } beat_report_t;

  // Tracks the detector state and the queue of results still owed
  class bpm_scoreboard;
    logic [15:0]         refractory;
    logic [15:0]         min_interval;
    logic [15:0]         max_interval;
    logic [SAMPLE_W-1:0] hyst;
    logic [SAMPLE_W-1:0] init_thr;
    logic [RATE_W-1:0]   rates [RING_DEPTH];
    int unsigned         slot;
    logic [TIME_W-1:0]   beat_start;
    logic [TIME_W-1:0]   last_detect;
    bit                  armed;
    logic [SAMPLE_W-1:0] threshold;
    beat_report_t        expected_reports [$];
    int                  mismatches;

    function new();
      refractory   = REFRACTORY_RST;
      min_interval = MIN_INT_RST;
      max_interval = MAX_INT_RST;
      hyst         = HYST_RST;
      init_thr     = INIT_THR_RST;
      clear_history();
      last_detect  = '0;
      threshold    = INIT_THR_RST;
      mismatches   = 0;
    endfunction

    function void clear_history();
      foreach (rates[i]) rates[i] = '0;
      slot       = 0;
      beat_start = '0;
      armed      = 1'b0;
    endfunction

    // the initial threshold value has no effect in the block, so it is just kept here
    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_REFRACTORY: refractory   = data;
        CFG_MIN_INT:    min_interval = data;
        CFG_MAX_INT:    max_interval = data;
        CFG_HYST:       hyst         = data[SAMPLE_W-1:0];
        CFG_INIT_THR:   init_thr     = data[SAMPLE_W-1:0];
        default: ;
      endcase
    endfunction

    // One sample step: beat decision, rate store, re-arm and threshold IIR
    function bit detect_beat(logic [SAMPLE_W-1:0] level, logic [TIME_W-1:0] stamp);
      logic [TIME_W-1:0] since_detect;
      logic [TIME_W-1:0] interval;
      logic [TIME_W-1:0] rate;
      int                rearm_level;
      int unsigned       acc;
      since_detect = stamp - last_detect;
      if (level > threshold && !armed && since_detect > TIME_W'(refractory)) begin
        interval    = stamp - beat_start;
        armed       = 1'b1;
        last_detect = stamp;
        beat_start  = stamp;
        if (interval > TIME_W'(min_interval) && interval < TIME_W'(max_interval)) begin
          rate = TIME_W'(RATE_NUM) / interval;
          if (rate > TIME_W'(RATE_MAX)) rate = TIME_W'(RATE_MAX);
          rates[slot] = rate[RATE_W-1:0];
          slot = (slot + 1) % RING_DEPTH;
        end
        return 1'b1;
      end
      // signed: a margin below zero never re-arms
      rearm_level = int'(threshold) - int'(hyst);
      if (int'(level) < rearm_level) armed = 1'b0;
      acc = IIR_KEEP * threshold + level;
      threshold = SAMPLE_W'(acc / IIR_DIV);
      return 1'b0;
    endfunction

    // Called on every input transfer
    function void predict_report(logic [FUNC_W-1:0] fn, logic [SAMPLE_W-1:0] level,
                                 logic [TIME_W-1:0] stamp);
      beat_report_t r;
      int unsigned  total;
      int unsigned  filled;
      r = '0;
      case (fn)
        FUNC_SAMPLE: r.beat = detect_beat(level, stamp);
        FUNC_CLEAR:  clear_history();
        FUNC_LOAD:   threshold = level;
        default: ;
      endcase
      total  = 0;
      filled = 0;
      foreach (rates[i]) begin
        if (rates[i] != 0) begin
          total  += rates[i];
          filled++;
        end
      end
      r.bpm      = (filled != 0) ? RATE_W'(total / filled) : '0;
      r.readings = COUNT_W'(filled);
      expected_reports.push_back(r);
    endfunction

    // Called on every result transfer
    function void check_report(logic beat, logic [RATE_W-1:0] bpm,
                               logic [COUNT_W-1:0] readings);
      beat_report_t want;
      if (expected_reports.size() == 0) begin
        $display("%0t: result with none expected: beat %0b bpm %0d count %0d",
                 $time, beat, bpm, readings);
        mismatches++;
        return;
      end
      want = expected_reports.pop_front();
      if (beat !== want.beat) begin
        $display("%0t: beat expected %0b actual %0b", $time, want.beat, beat);
        mismatches++;
      end
      if (bpm !== want.bpm) begin
        $display("%0t: bpm expected %0d actual %0d", $time, want.bpm, bpm);
        mismatches++;
      end
      if (readings !== want.readings) begin
        $display("%0t: reading_count expected %0d actual %0d",
                 $time, want.readings, readings);
        mismatches++;
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic [FUNC_W-1:0]     in_func;
  logic [SAMPLE_W-1:0]   in_sample;
  logic [TIME_W-1:0]     in_time_ms;
  logic                  out_valid;
  logic                  out_ready;
  logic                  out_beat;
  logic [RATE_W-1:0]     out_bpm;
  logic [COUNT_W-1:0]    out_reading_count;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  bpm_scoreboard     sb;
  bit                in_calm;
  bit                out_calm;
  bit                hold_request;
  logic [TIME_W-1:0] now_ms;

  pulse_beat_detect_bpm u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_func           (in_func),
    .in_sample         (in_sample),
    .in_time_ms        (in_time_ms),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_beat          (out_beat),
    .out_bpm           (out_bpm),
    .out_reading_count (out_reading_count),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always #1 clk = ~clk;

  // One input transfer; valid stays up when the next item follows at once
  task automatic send_item(input logic [FUNC_W-1:0] fn, input logic [SAMPLE_W-1:0] level,
                           input logic [TIME_W-1:0] stamp);
    int gap;
    gap = in_calm ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_func    <= fn;
    in_sample  <= level;
    in_time_ms <= stamp;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.predict_report(fn, level, stamp);
  endtask

  // Stop offering and wait for every owed result
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.expected_reports.size() != 0);
  endtask

  // Back-to-back register writes, unused indexes included
  task automatic program_registers(input logic [CFG_DATA_W-1:0] refr,
                                   input logic [CFG_DATA_W-1:0] min_int,
                                   input logic [CFG_DATA_W-1:0] max_int,
                                   input logic [CFG_DATA_W-1:0] hyst,
                                   input logic [CFG_DATA_W-1:0] init_thr);
    logic [CFG_DATA_W-1:0] vals [CFG_SLOTS];
    int                    i;
    foreach (vals[j]) vals[j] = CFG_DATA_W'($urandom);
    vals[CFG_REFRACTORY] = refr;
    vals[CFG_MIN_INT]    = min_int;
    vals[CFG_MAX_INT]    = max_int;
    vals[CFG_HYST]       = hyst;
    vals[CFG_INIT_THR]   = init_thr;
    for (i = 0; i < CFG_SLOTS; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_data  <= vals[i];
      @(posedge clk);
      sb.write_register(CFG_IDX_W'(i), vals[i]);
    end
    cfg_we <= 1'b0;
  endtask

  // Value one below, at or one above a limit
  function automatic logic [TIME_W-1:0] around(input logic [TIME_W-1:0] v);
    logic [TIME_W-1:0] p;
    p = v + $urandom_range(0, 2);
    return (p == 0) ? p : p - 1;
  endfunction

  // One pulse: peak, maybe a second high sample, then low samples
  task automatic send_beat(output int items);
    logic [TIME_W-1:0] period;
    int                n_low;
    int                j;
    case ($urandom_range(0, 9))
      0:       period = around(TIME_W'(sb.min_interval));
      1:       period = around(TIME_W'(sb.max_interval));
      2:       period = around(TIME_W'(sb.refractory));
      3:       period = $urandom_range(1, 250);
      default: period = $urandom_range(300, 2000);
    endcase
    items = 0;
    send_item(FUNC_SAMPLE, SAMPLE_W'($urandom_range(600, 1023)), now_ms);
    items++;
    if ($urandom_range(0, 3) == 0) begin
      send_item(FUNC_SAMPLE, SAMPLE_W'($urandom_range(600, 1023)), now_ms + 1);
      items++;
    end
    n_low = $urandom_range(1, 3);
    for (j = 1; j <= n_low; j++) begin
      send_item(FUNC_SAMPLE, SAMPLE_W'($urandom_range(0, 300)),
                now_ms + period * j / (n_low + 1));
      items++;
    end
    now_ms += period;
  endtask

  // Odd items: clear, load, unused code, wild timestamps
  task automatic send_noise();
    case ($urandom_range(0, 9))
      0: send_item(FUNC_CLEAR, SAMPLE_W'($urandom), TIME_W'($urandom));
      1: send_item(FUNC_LOAD, SAMPLE_W'($urandom), TIME_W'($urandom));
      2: send_item(FUNC_UNUSED, SAMPLE_W'($urandom), TIME_W'($urandom));
      3: send_item(FUNC_SAMPLE, SAMPLE_W'($urandom), TIME_W'($urandom));
      default: begin
        now_ms += $urandom_range(0, 50);
        send_item(FUNC_SAMPLE, SAMPLE_W'($urandom), now_ms);
      end
    endcase
  endtask

  task automatic run_random(input int n);
    int sent;
    int items;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(0, 19) == 0) in_calm = !in_calm;
      if ($urandom_range(0, 19) == 0) out_calm = !out_calm;
      if ($urandom_range(0, 9) < 8) begin
        send_beat(items);
        sent += items;
      end else begin
        send_noise();
        sent++;
      end
    end
  endtask

  // Result side: random stalls per transfer, plus one long hold-off on request
  initial begin : result_sink
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left  = 0;
    out_ready  = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        sb.check_report(out_beat, out_bpm, out_reading_count);
        stall_left = out_calm ? 0 : $urandom_range(0, 6);
      end else if (stall_left > 0) begin
        stall_left--;
      end
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) hold_left--;
      out_ready <= (hold_left == 0) && (stall_left == 0);
    end
  end

  // Run limit
  initial begin : watchdog
    int unsigned cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin : stimulus
    int ph;
    sb           = new();
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_func      = FUNC_SAMPLE;
    in_sample    = '0;
    in_time_ms   = '0;
    cfg_we       = 1'b0;
    cfg_index    = CFG_REFRACTORY;
    cfg_data     = '0;
    in_calm      = 1'b0;
    out_calm     = 1'b0;
    hold_request = 1'b0;
    now_ms       = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed pass at reset settings
    send_item(FUNC_SAMPLE, '0, 32'd0);
    send_item(FUNC_SAMPLE, LEVEL_TOP, 32'd0);     // inside refractory
    send_item(FUNC_SAMPLE, LEVEL_TOP, 32'd301);   // first beat, interval just over min
    send_item(FUNC_SAMPLE, LEVEL_TOP, 32'd350);   // still armed
    send_item(FUNC_SAMPLE, '0, 32'd500);          // re-arm
    send_item(FUNC_SAMPLE, LEVEL_TOP, 32'd800);
    send_item(FUNC_SAMPLE, '0, 32'd900);
    send_item(FUNC_SAMPLE, LEVEL_TOP, 32'd3800);  // interval equal to max, not stored
    send_item(FUNC_SAMPLE, '0, 32'd3850);
    send_item(FUNC_SAMPLE, LEVEL_TOP, 32'd4100);  // refractory exactly met, no beat
    send_item(FUNC_SAMPLE, LEVEL_TOP, 32'd4101);
    send_item(FUNC_SAMPLE, '0, 32'd4200);
    send_item(FUNC_SAMPLE, LEVEL_TOP, 32'd4500);  // ring full
    send_item(FUNC_SAMPLE, '0, 32'd4600);
    send_item(FUNC_SAMPLE, LEVEL_TOP, 32'd4900);  // ring pointer wraps
    send_item(FUNC_LOAD, LEVEL_TOP, 32'd5000);
    send_item(FUNC_SAMPLE, LEVEL_TOP, 32'd5400);  // equal to threshold
    send_item(FUNC_LOAD, SAMPLE_W'(50), 32'd5500);
    send_item(FUNC_SAMPLE, '0, 32'd5600);         // margin below zero keeps flag
    send_item(FUNC_SAMPLE, LEVEL_TOP, 32'd6000);
    send_item(FUNC_UNUSED, LEVEL_TOP, 32'hFFFF_FFFF);
    send_item(FUNC_CLEAR, LEVEL_TOP, 32'hFFFF_FFFF);
    send_item(FUNC_SAMPLE, LEVEL_TOP, 32'hFFFF_FF00);
    send_item(FUNC_LOAD, SAMPLE_W'(512), 32'hFFFF_FFFF);
    send_item(FUNC_SAMPLE, '0, 32'hFFFF_FFFF);
    send_item(FUNC_SAMPLE, LEVEL_TOP, 32'h0000_0080); // timestamp wrapped
    settle();

    // Random phases, each under its own register setting
    for (ph = 0; ph < PHASE_COUNT; ph++) begin
      case (ph)
        0: program_registers('0, '0, CFG_TOP, '0, '0);
        1: program_registers(CFG_TOP, CFG_TOP, CFG_DATA_W'(1), CFG_DATA_W'(LEVEL_TOP),
                             CFG_DATA_W'(LEVEL_TOP));
        default: program_registers(CFG_DATA_W'($urandom_range(0, 400)),
                                   CFG_DATA_W'($urandom_range(0, 400)),
                                   CFG_DATA_W'($urandom_range(600, 3000)),
                                   {6'($urandom), 10'($urandom_range(0, 300))},
                                   CFG_DATA_W'($urandom));
      endcase
      now_ms = (ph == 2) ? TIME_W'(0) - $urandom_range(2000, 20000) : TIME_W'($urandom);
      // long receiver hold-off fills the block and backs up the input
      if (ph == 3) hold_request = 1'b1;
      run_random(PHASE_ITEMS);
      settle();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
